>>> src/lacb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lacb_pkg
// Shared types, constants and helpers for the layer alpha blend compositor.
// ----------------------------------------------------------------------------
package lacb_pkg;

   localparam int unsigned PIXEL_W    = 32;
   localparam int unsigned CHAN_W     = 8;
   localparam int unsigned WEIGHT_W   = 5;
   localparam int unsigned NUM_CHAN   = 3;
   localparam int unsigned PROD_W     = CHAN_W + WEIGHT_W;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = WEIGHT_W;

   localparam logic [CHAN_W-1:0]   CHAN_MAX   = 8'd255;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 5'd16;
   localparam logic [PROD_W-1:0]   ROUND_HALF = 13'd8;

   localparam logic [WEIGHT_W-1:0] TOP_WEIGHT_RESET    = 5'd16;
   localparam logic [WEIGHT_W-1:0] BOTTOM_WEIGHT_RESET = 5'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLEND_ENABLE   = 3'd0,
      CSR_THREE_D_ENABLE = 3'd1,
      CSR_OBJECT_ENABLE  = 3'd2,
      CSR_TOP_WEIGHT     = 3'd3,
      CSR_BOTTOM_WEIGHT  = 3'd4
   } csr_index_type;

   // Per-layer control that travels with a pixel down the pipeline.
   typedef struct packed {
      logic                apply;
      logic                blend;
      logic [WEIGHT_W-1:0] top_w;
      logic [WEIGHT_W-1:0] bottom_w;
   } layer_ctrl_type;

   function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [WEIGHT_W-1:0] w);
      sat_weight = (w > WEIGHT_MAX) ? WEIGHT_MAX : w;
   endfunction

   function automatic logic [CHAN_W-1:0] pixel_alpha(input logic [PIXEL_W-1:0] px);
      pixel_alpha = px[PIXEL_W-1 -: CHAN_W];
   endfunction

endpackage
`default_nettype wire

>>> src/lacb_layer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lacb_layer
// Two-stage layer placement: weighted channel products, then round, saturate
// and select between replace, pass-through and blend.
// ----------------------------------------------------------------------------
module lacb_layer (
   input  wire logic                          clock,
   input  wire logic                          en_mul,
   input  wire logic                          en_sum,
   input  wire lacb_pkg::layer_ctrl_type      ctrl,
   input  wire logic [lacb_pkg::PIXEL_W-1:0]  up_pixel,
   input  wire logic [lacb_pkg::PIXEL_W-1:0]  low_pixel,
   output logic      [lacb_pkg::PIXEL_W-1:0]  out_pixel
);

   localparam int unsigned CW = lacb_pkg::CHAN_W;
   localparam int unsigned WW = lacb_pkg::WEIGHT_W;
   localparam int unsigned PW = lacb_pkg::PROD_W;
   localparam int unsigned NC = lacb_pkg::NUM_CHAN;

   lacb_pkg::layer_ctrl_type          ctrl_ff;
   logic [lacb_pkg::PIXEL_W-1:0]      up_ff;
   logic [lacb_pkg::PIXEL_W-1:0]      low_ff;
   logic [PW-1:0]                     prod_up_ff  [NC];
   logic [PW-1:0]                     prod_low_ff [NC];
   logic [PW-1:0]                     prod_up_in  [NC];
   logic [PW-1:0]                     prod_low_in [NC];
   logic [lacb_pkg::PIXEL_W-1:0]      mix_pixel;
   logic [lacb_pkg::PIXEL_W-1:0]      result_in;
   logic [lacb_pkg::PIXEL_W-1:0]      result_ff;
   logic [CW-1:0]                     up_alpha;
   logic [CW-1:0]                     low_alpha;

   // Multiply stage
   always_comb begin
      for (int k = 0; k < NC; k++) begin
         prod_up_in[k]  = {{WW{1'b0}}, up_pixel[k*CW +: CW]} *
                          {{CW{1'b0}}, ctrl.top_w};
         prod_low_in[k] = {{WW{1'b0}}, low_pixel[k*CW +: CW]} *
                          {{CW{1'b0}}, ctrl.bottom_w};
      end
   end

   always_ff @(posedge clock) begin
      if (en_mul) begin
         ctrl_ff <= ctrl;
         up_ff   <= up_pixel;
         low_ff  <= low_pixel;
         for (int k = 0; k < NC; k++) begin
            prod_up_ff[k]  <= prod_up_in[k];
            prod_low_ff[k] <= prod_low_in[k];
         end
      end
   end

   // Sum, round, saturate and select stage
   always_comb begin
      logic [PW-1:0]    sum;
      logic [PW-5:0]    shifted;
      up_alpha  = lacb_pkg::pixel_alpha(up_ff);
      low_alpha = lacb_pkg::pixel_alpha(low_ff);
      mix_pixel = '0;
      for (int k = 0; k < NC; k++) begin
         sum     = prod_up_ff[k] + prod_low_ff[k] + lacb_pkg::ROUND_HALF;
         shifted = sum[PW-1:4];
         mix_pixel[k*CW +: CW] = (shifted > {1'b0, lacb_pkg::CHAN_MAX}) ?
                                 lacb_pkg::CHAN_MAX : shifted[CW-1:0];
      end
      mix_pixel[lacb_pkg::PIXEL_W-1 -: CW] = (up_alpha > low_alpha) ? up_alpha : low_alpha;

      if (!ctrl_ff.apply || up_alpha == '0) begin
         result_in = low_ff;
      end else if (!ctrl_ff.blend || low_alpha == '0) begin
         result_in = up_ff;
      end else begin
         result_in = mix_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (en_sum) begin
         result_ff <= result_in;
      end
   end

   assign out_pixel = result_ff;

endmodule
`default_nettype wire

>>> src/layer_alpha_blend_compositor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// layer_alpha_blend_compositor
// Composes a 3D layer and then an object layer over a background pixel.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one composed pixel per clock through
// an input register, then two stages per layer (a stage of 8x5 channel
// multiplies and a stage of round, saturate and select) for the 3D layer and
// then the object layer, the last of which is the output register.
// Backpressure on rsp_tready stalls each stage only while the stage ahead of
// it is full, so bubbles close up. Registers are written through the csr_
// port, which is ready whenever reset is low; write them only while no
// pixel is in flight.
// ----------------------------------------------------------------------------
module layer_alpha_blend_compositor (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Pixel input
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata: background_pixel[31:0], object_pixel[63:32], three_d_pixel[95:64]
   input  wire logic [3*lacb_pkg::PIXEL_W-1:0]    req_tdata,
   // tuser: engine_select[0]
   input  wire logic                              req_tuser,
   // Composed output
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata: composed_pixel[31:0]
   output logic      [lacb_pkg::PIXEL_W-1:0]      rsp_tdata,
   // Register write
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [lacb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lacb_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int unsigned PXW    = lacb_pkg::PIXEL_W;
   localparam int unsigned NSTAGE = 5;

   logic [1:0]                     blend_mask_ff;
   logic [1:0]                     three_d_mask_ff;
   logic [1:0]                     object_mask_ff;
   logic [lacb_pkg::WEIGHT_W-1:0]  top_weight_ff;
   logic [lacb_pkg::WEIGHT_W-1:0]  bottom_weight_ff;

   logic [NSTAGE-1:0]              valid_ff;
   logic [NSTAGE:0]                stage_en;

   lacb_pkg::layer_ctrl_type       three_d_ctrl_in;
   lacb_pkg::layer_ctrl_type       object_ctrl_in;
   lacb_pkg::layer_ctrl_type       three_d_ctrl_ff;
   lacb_pkg::layer_ctrl_type       object_ctrl_s0_ff;
   lacb_pkg::layer_ctrl_type       object_ctrl_s1_ff;
   lacb_pkg::layer_ctrl_type       object_ctrl_s2_ff;

   logic [PXW-1:0]                 background_ff;
   logic [PXW-1:0]                 object_s0_ff;
   logic [PXW-1:0]                 object_s1_ff;
   logic [PXW-1:0]                 object_s2_ff;
   logic [PXW-1:0]                 three_d_ff;
   logic [PXW-1:0]                 mid_pixel;
   logic [PXW-1:0]                 final_pixel;

   // Register file
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mask_ff    <= '0;
         three_d_mask_ff  <= '0;
         object_mask_ff   <= '0;
         top_weight_ff    <= lacb_pkg::TOP_WEIGHT_RESET;
         bottom_weight_ff <= lacb_pkg::BOTTOM_WEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (lacb_pkg::csr_index_type'(csr_index))
            lacb_pkg::CSR_BLEND_ENABLE:   blend_mask_ff    <= csr_data[1:0];
            lacb_pkg::CSR_THREE_D_ENABLE: three_d_mask_ff  <= csr_data[1:0];
            lacb_pkg::CSR_OBJECT_ENABLE:  object_mask_ff   <= csr_data[1:0];
            lacb_pkg::CSR_TOP_WEIGHT:     top_weight_ff    <= csr_data;
            lacb_pkg::CSR_BOTTOM_WEIGHT:  bottom_weight_ff <= csr_data;
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   // Stage i loads when it is empty or its contents move on
   always_comb begin
      stage_en[NSTAGE] = rsp_tready;
      for (int i = NSTAGE - 1; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   assign req_tready = stage_en[0] && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NSTAGE; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // Decode the engine's mask bits and weights at the input stage
   always_comb begin
      three_d_ctrl_in.apply    = three_d_mask_ff[req_tuser];
      three_d_ctrl_in.blend    = blend_mask_ff[req_tuser];
      three_d_ctrl_in.top_w    = lacb_pkg::sat_weight(top_weight_ff);
      three_d_ctrl_in.bottom_w = lacb_pkg::sat_weight(bottom_weight_ff);
      object_ctrl_in           = three_d_ctrl_in;
      object_ctrl_in.apply     = object_mask_ff[req_tuser];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         background_ff     <= req_tdata[PXW-1:0];
         object_s0_ff      <= req_tdata[2*PXW-1:PXW];
         three_d_ff        <= req_tdata[3*PXW-1:2*PXW];
         three_d_ctrl_ff   <= three_d_ctrl_in;
         object_ctrl_s0_ff <= object_ctrl_in;
      end
      if (stage_en[1]) begin
         object_s1_ff      <= object_s0_ff;
         object_ctrl_s1_ff <= object_ctrl_s0_ff;
      end
      if (stage_en[2]) begin
         object_s2_ff      <= object_s1_ff;
         object_ctrl_s2_ff <= object_ctrl_s1_ff;
      end
   end

   lacb_layer u_three_d_layer (
      .clock     (clock),
      .en_mul    (stage_en[1]),
      .en_sum    (stage_en[2]),
      .ctrl      (three_d_ctrl_ff),
      .up_pixel  (three_d_ff),
      .low_pixel (background_ff),
      .out_pixel (mid_pixel)
   );

   lacb_layer u_object_layer (
      .clock     (clock),
      .en_mul    (stage_en[3]),
      .en_sum    (stage_en[4]),
      .ctrl      (object_ctrl_s2_ff),
      .up_pixel  (object_s2_ff),
      .low_pixel (mid_pixel),
      .out_pixel (final_pixel)
   );

   assign rsp_tvalid = valid_ff[NSTAGE-1];
   assign rsp_tdata  = final_pixel;

   // A stalled stage 2 keeps its item
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[2] && !stage_en[3]) |=> valid_ff[2])
      else $error("pipeline stage lost an item while stalled");

   // Object layer disabled: output equals the 3D stage result
   a_object_bypass: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && stage_en[4] && !u_object_layer.ctrl_ff.apply) |=>
      (rsp_tdata == $past(u_object_layer.low_ff)))
      else $error("disabled object layer altered the pixel");

   // Input is refused only when every stage is full
   a_ready_when_room: assert property (@(posedge clock) disable iff (reset)
      (valid_ff != {NSTAGE{1'b1}}) |-> req_tready)
      else $error("input stalled while the pipeline had room");

endmodule
`default_nettype wire
